// ===== rtl/rtb_pkg.sv =====
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared types and constants of the row transition blanker.
// ----------------------------------------------------------------------------
package rtb_pkg;

  // default line store depth in pixels per bank
  localparam int MAX_WIDTH_DEF = 256;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int TRANS_W   = 8;

  // register reset values and the transition count saturation value
  localparam logic [CFG_W-1:0]   ROW_WIDTH_RST = 9'd136;
  localparam logic [TRANS_W-1:0] MAX_TRANS_RST = 8'd10;
  localparam logic [TRANS_W-1:0] TRANS_SAT     = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH       = 1'b0,
    REG_MAX_TRANSITIONS = 1'b1
  } cfg_reg_t;

  // input word opcodes
  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // a line store read issued for one result word
  typedef struct packed {
    logic valid;
    logic blank;
    logic last;
  } emit_t;

endpackage

// ===== rtl/rtb_if.sv =====
// ----------------------------------------------------------------------------
// rtb_in_if / rtb_out_if
// Valid/ready channels carrying input pixel words and result words.
// ----------------------------------------------------------------------------
interface rtb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [rtb_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface rtb_out_if;
  logic                      valid;
  logic                      ready;
  logic [rtb_pkg::PIX_W-1:0] out_pixel;
  logic                      row_last;

  modport source (output valid, output out_pixel, output row_last, input ready);
  modport sink   (input valid, input out_pixel, input row_last, output ready);
endinterface

// ===== rtl/rtb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtb_ctrl
// Row sequencer: column, transition count, bank select, pending row and
// drain tracking, configuration registers, line store addressing.
// ----------------------------------------------------------------------------
module rtb_ctrl #(
  parameter int MAX_WIDTH = rtb_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(2 * MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          op,
  input  logic [rtb_pkg::PIX_W-1:0]     pixel,
  input  logic                          cfg_wr_en,
  input  logic [rtb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtb_pkg::CFG_W-1:0]     cfg_data,
  output rtb_pkg::emit_t                emit,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [rtb_pkg::PIX_W-1:0]     wr_data,
  output logic [AW-1:0]                 rd_addr
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (CW > rtb_pkg::CFG_W) ? CW : rtb_pkg::CFG_W;

  logic [rtb_pkg::CFG_W-1:0]   row_width;
  logic [rtb_pkg::TRANS_W-1:0] max_transitions;

  logic                        write_bank;
  logic [COL_W-1:0]            column;
  logic [rtb_pkg::PIX_W-1:0]   prev_pixel;
  logic [rtb_pkg::TRANS_W-1:0] transitions;
  logic                        pending_valid;
  logic                        pending_blank;
  logic                        draining;

  logic [EW-1:0]               rw_ext;
  logic [EW-1:0]               eff_width;
  logic [EW-1:0]               col_inc;
  logic                        col_end;
  logic                        is_drain;
  logic                        drain_ok;
  logic                        pix_ok;
  logic [rtb_pkg::TRANS_W-1:0] transitions_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width       <= rtb_pkg::ROW_WIDTH_RST;
      max_transitions <= rtb_pkg::MAX_TRANS_RST;
    end else if (cfg_wr_en) begin
      unique case (rtb_pkg::cfg_reg_t'(cfg_index))
        rtb_pkg::REG_ROW_WIDTH:       row_width       <= cfg_data;
        rtb_pkg::REG_MAX_TRANSITIONS: max_transitions <= cfg_data[rtb_pkg::TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective width, saturated to 2 .. MAX_WIDTH
  always_comb begin
    rw_ext = EW'(row_width);
    if (rw_ext < EW'(2))
      eff_width = EW'(2);
    else if (rw_ext > EW'(MAX_WIDTH))
      eff_width = EW'(MAX_WIDTH);
    else
      eff_width = rw_ext;
  end

  assign col_inc  = EW'(column) + EW'(1);
  assign col_end  = (col_inc >= eff_width);
  assign is_drain = (rtb_pkg::op_t'(op) == rtb_pkg::OP_DRAIN);
  assign drain_ok = pending_valid && ((column == '0) || draining);
  assign pix_ok   = !draining;

  // count a change against the previous pixel, saturating
  always_comb begin
    transitions_next = transitions;
    if ((column != '0) && (pixel != prev_pixel) && (transitions != rtb_pkg::TRANS_SAT))
      transitions_next = transitions + rtb_pkg::TRANS_W'(1);
  end

  // line store access: write the fill bank, read the other one
  assign wr_en   = accept && !is_drain && pix_ok;
  assign wr_addr = write_bank ? AW'(column) + AW'(MAX_WIDTH) : AW'(column);
  assign wr_data = pixel;
  assign rd_addr = write_bank ? AW'(column) : AW'(column) + AW'(MAX_WIDTH);

  always_comb begin
    emit.valid = accept && (is_drain ? drain_ok : (pix_ok && pending_valid));
    emit.blank = pending_blank;
    emit.last  = col_end;
  end

  // row state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_bank    <= 1'b0;
      column        <= '0;
      prev_pixel    <= '0;
      transitions   <= '0;
      pending_valid <= 1'b0;
      pending_blank <= 1'b0;
      draining      <= 1'b0;
    end else if (accept) begin
      if (is_drain) begin
        if (drain_ok) begin
          if (col_end) begin
            column        <= '0;
            pending_valid <= 1'b0;
            draining      <= 1'b0;
          end else begin
            column   <= col_inc[COL_W-1:0];
            draining <= 1'b1;
          end
        end
      end else if (pix_ok) begin
        prev_pixel <= pixel;
        if (col_end) begin
          pending_valid <= 1'b1;
          pending_blank <= (transitions_next <= max_transitions);
          write_bank    <= ~write_bank;
          column        <= '0;
          transitions   <= '0;
        end else begin
          column      <= col_inc[COL_W-1:0];
          transitions <= transitions_next;
        end
      end
    end
  end

endmodule

// ===== rtl/rtb_line_ram.sv =====
// ----------------------------------------------------------------------------
// rtb_line_ram
// Ping-pong line store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rtb_line_ram #(
  parameter int DEPTH = 2 * rtb_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rtb_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rtb_pkg::PIX_W-1:0] rd_data
);

  logic [rtb_pkg::PIX_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= wr_data;
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en)
      rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/rtb_out_buf.sv =====
// ----------------------------------------------------------------------------
// rtb_out_buf
// Holds read requests while the store answers, applies blanking and
// queues result words in a three-deep buffer for the output channel.
// ----------------------------------------------------------------------------
module rtb_out_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  rtb_pkg::emit_t            emit,
  input  logic [rtb_pkg::PIX_W-1:0] rd_data,
  output logic                      space,
  rtb_out_if.source                 results
);

  localparam int DEPTH = 3;

  logic                      s1_valid;
  logic                      s1_blank;
  logic                      s1_last;

  logic [rtb_pkg::PIX_W-1:0] q_pixel [DEPTH];
  logic                      q_last  [DEPTH];
  logic [1:0]                head;
  logic [1:0]                tail;
  logic [1:0]                count;
  logic                      push;
  logic                      pop;
  logic [2:0]                used;

  // stage waiting for the store read
  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else
      s1_valid <= emit.valid;
  end

  always_ff @(posedge clk) begin
    s1_blank <= emit.blank;
    s1_last  <= emit.last;
  end

  assign push  = s1_valid;
  assign pop   = results.valid && results.ready;
  assign used  = 3'(count) + 3'(s1_valid);
  assign space = (used < 3'(DEPTH));

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_pixel[tail] <= s1_blank ? '0 : rd_data;
      q_last[tail]  <= s1_last;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push)
        tail <= (tail == 2'(DEPTH - 1)) ? '0 : tail + 2'd1;
      if (pop)
        head <= (head == 2'(DEPTH - 1)) ? '0 : head + 2'd1;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign results.valid     = (count != '0);
  assign results.out_pixel = q_pixel[head];
  assign results.row_last  = q_last[head];

endmodule

// ===== rtl/row_transition_blanker.sv =====
// ----------------------------------------------------------------------------
// row_transition_blanker
// Blanks rows of a binarised raster stream with few value changes; output
// runs one row behind through a ping-pong line store.
// ----------------------------------------------------------------------------
// Throughput: one word per clock; ready drops only when three result words
//   are queued or in flight and the output side stalls.
// Result path: an input word that causes a result word starts a line store read;
//   the word passes through the registered read, then the output queue.
// Reset: synchronous, clears control state and configuration registers; line store content
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module row_transition_blanker #(
  parameter int MAX_WIDTH = rtb_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  rtb_in_if.sink                        pixels,
  rtb_out_if.source                     results,
  input  logic                          cfg_wr_en,
  input  logic [rtb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = 2 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic                      accept;
  logic                      space;
  rtb_pkg::emit_t            emit;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [rtb_pkg::PIX_W-1:0] wr_data;
  logic [AW-1:0]             rd_addr;
  logic [rtb_pkg::PIX_W-1:0] rd_data;

  assign pixels.ready = space;
  assign accept       = pixels.valid && space;

  // row sequencing and addressing
  rtb_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (pixels.op),
    .pixel     (pixels.pixel),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .emit      (emit),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr)
  );

  // line store
  rtb_line_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (emit.valid),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // blanking and output queue
  rtb_out_buf u_out (
    .clk     (clk),
    .rst     (rst),
    .emit    (emit),
    .rd_data (rd_data),
    .space   (space),
    .results (results)
  );

endmodule

// ===== rtl/rtb_checker.sv =====
// ----------------------------------------------------------------------------
// rtb_checker
// Port-level checks of the row transition blanker, bound to the top level.
// ----------------------------------------------------------------------------
module rtb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rtb_pkg::PIX_W-1:0] out_pixel,
  input logic                      row_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel) && $stable(row_last)))
    else $error("result word changed while stalled");

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word after reset");

  // an empty queue starts showing a word only after an accepted input word, via the store read stage
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without a causing input word");

  // back-pressure only while results are queued
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result word queued");

endmodule

bind row_transition_blanker rtb_checker u_rtb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_pixel (results.out_pixel),
  .row_last  (results.row_last)
);
